@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SHSE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/shse_pkg.sv @@
// ----------------------------------------------------------------------------
// String hash set engine package
// Sizes, command and status codes, and the types shared by the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package shse_pkg;

    localparam int HASH_W           = 64;
    localparam int CHAR_W           = 8;
    localparam int CMD_W            = 2;
    // Multiplier 31 is built as (h << 5) - h.
    localparam int MULT_SHIFT       = 5;

    // Bucket is the low hash bits, so BUCKETS must be a power of two.
    localparam int BUCKETS          = 1024;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int TOTAL_SLOTS      = BUCKETS * SLOTS_PER_BUCKET;
    localparam int BUCKET_W         = $clog2(BUCKETS);
    // Count wraps modulo 8192.
    localparam int COUNT_W          = 13;

    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [HASH_W-1:0] hash;
    } op_t;

    typedef struct packed {
        logic [SLOTS_PER_BUCKET-1:0]             valid;
        logic [SLOTS_PER_BUCKET-1:0][HASH_W-1:0] hashes;
    } row_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/shse_if.sv @@
// ----------------------------------------------------------------------------
// String hash set engine channels
// Character input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface shse_char_if;
    logic                                valid;
    logic                                ready;
    logic [shse_pkg::CMD_W-1:0]          cmd;
    logic signed [shse_pkg::CHAR_W-1:0]  char_code;
    logic                                char_valid;
    logic                                last_char;

    modport source (output valid, cmd, char_code, char_valid, last_char, input ready);
    modport sink   (input valid, cmd, char_code, char_valid, last_char, output ready);
endinterface

interface shse_result_if;
    logic                          valid;
    logic                          ready;
    logic                          status;
    logic                          found;
    logic [shse_pkg::COUNT_W-1:0]  element_count;

    modport source (output valid, status, found, element_count, input ready);
    modport sink   (input valid, status, found, element_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/string_hash_set_engine_top.sv @@
// ----------------------------------------------------------------------------
// String hash set engine
// Polynomial string hash (h = h*31 + c) feeding a bucketed hash set.
// ----------------------------------------------------------------------------
// Strings arrive one signed character per item; each valid character folds
// into a 64-bit wrapping hash, one item per cycle while the operation queue
// has room. The item flagged last_char runs its command (add, contains,
// delete) on the bucket picked by the hash's low bits and yields one result;
// other items yield none. The front end keeps taking characters while the
// back end works, buffered by a two-entry operation queue. Each table
// operation first reads the bucket row from the bucket store into a register,
// then compares its slots, writes the row back and registers the result. After
// reset the back end clears all 1024 bucket rows of the store, one per cycle;
// characters are still accepted until the queue fills, and queued operations
// run once the clear is done.
`timescale 1ns / 1ps
`default_nettype none

module string_hash_set_engine_top (
    input  logic          clk,
    input  logic          rst_n,
    shse_char_if.sink     chars,
    shse_result_if.source results
);

    shse_pkg::op_t front_op;
    logic          front_valid;
    logic          front_ready;
    shse_pkg::op_t back_op;
    logic          back_valid;
    logic          back_ready;

    shse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .op       (front_op),
        .op_valid (front_valid),
        .op_ready (front_ready)
    );

    shse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_op    (front_op),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_op     (back_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    shse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (back_op),
        .op_valid (back_valid),
        .op_ready (back_ready),
        .results  (results)
    );

endmodule

`default_nettype wire

@@ rtl/core/shse_front.sv @@
// ----------------------------------------------------------------------------
// Hash front end
// Folds characters into the running hash and issues an operation on the
// last item of each string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shse_front (
    input  logic             clk,
    input  logic             rst_n,
    shse_char_if.sink        chars,
    output shse_pkg::op_t    op,
    output logic             op_valid,
    input  logic             op_ready
);

    logic [shse_pkg::HASH_W-1:0] hash_reg;
    logic [shse_pkg::HASH_W-1:0] hash_next;
    logic [shse_pkg::HASH_W-1:0] char_ext;
    logic [shse_pkg::HASH_W-1:0] hash_step;
    logic [shse_pkg::HASH_W-1:0] hash_upd;
    logic                        accept;

    always_comb
    begin
        char_ext  = {{(shse_pkg::HASH_W - shse_pkg::CHAR_W){chars.char_code[shse_pkg::CHAR_W-1]}},
                     chars.char_code};
        hash_step = (hash_reg << shse_pkg::MULT_SHIFT) - hash_reg + char_ext;
        hash_upd  = chars.char_valid ? hash_step : hash_reg;
    end

    assign chars.ready = op_ready;
    assign accept      = chars.valid && op_ready;
    assign op_valid    = chars.valid && chars.last_char;
    assign op.cmd      = chars.cmd;
    assign op.hash     = hash_upd;

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            // restart the hash once the string is handed off
            hash_next = chars.last_char ? '0 : hash_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/shse_queue.sv @@
// ----------------------------------------------------------------------------
// Operation queue
// Short FIFO that decouples the hash front end from the table back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shse_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  shse_pkg::op_t    push_op,
    input  logic             push_valid,
    output logic             push_ready,
    output shse_pkg::op_t    pop_op,
    output logic             pop_valid,
    input  logic             pop_ready
);

    shse_pkg::op_t               entries_reg [shse_pkg::QUEUE_DEPTH];
    logic [shse_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [shse_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [shse_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        push;
    logic                        pop;

    assign push_ready = (count_reg != shse_pkg::QCNT_W'(shse_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == shse_pkg::QPTR_W'(shse_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == shse_pkg::QPTR_W'(shse_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/shse_back.sv @@
// ----------------------------------------------------------------------------
// Table back end
// Clears the bucket store after reset, then runs add, contains and delete
// against one bucket row per operation and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module shse_back (
    input  logic             clk,
    input  logic             rst_n,
    input  shse_pkg::op_t    op,
    input  logic             op_valid,
    output logic             op_ready,
    shse_result_if.source    results
);

    localparam int S = shse_pkg::SLOTS_PER_BUCKET;

    shse_pkg::back_state_t         state_reg, state_next;
    logic [shse_pkg::BUCKET_W-1:0] clr_idx_reg, clr_idx_next;
    logic [shse_pkg::COUNT_W-1:0]  count_reg, count_next;

    shse_pkg::row_t                mem [shse_pkg::BUCKETS];
    shse_pkg::row_t                rd_row_reg;
    shse_pkg::op_t                 op_reg;

    logic                          pop;
    logic                          mem_we;
    logic [shse_pkg::BUCKET_W-1:0] wr_addr;
    shse_pkg::row_t                wr_row;

    logic [S-1:0]                  match_vec;
    logic [S-1:0]                  hit_oh;
    logic [S-1:0]                  free_vec;
    logic [S-1:0]                  free_oh;
    logic                          hit_any;
    logic                          free_any;

    logic                          load_out;
    logic                          res_status;
    logic                          out_valid_reg, out_valid_next;
    logic                          status_reg;
    logic                          found_reg;
    logic [shse_pkg::COUNT_W-1:0]  elem_count_reg;

    assign op_ready = (state_reg == shse_pkg::BK_IDLE) && (!out_valid_reg || results.ready);
    assign pop      = op_ready && op_valid;

    // slot search on the registered bucket row
    always_comb
    begin
        for (int s = 0; s < S; s++)
        begin
            match_vec[s] = rd_row_reg.valid[s] && (rd_row_reg.hashes[s] == op_reg.hash);
        end
        free_vec = ~rd_row_reg.valid;
        hit_oh   = match_vec & (~match_vec + 1'b1);
        free_oh  = free_vec & (~free_vec + 1'b1);
        hit_any  = |match_vec;
        free_any = |free_vec;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shse_pkg::BK_CLEAR:
            begin
                if (clr_idx_reg == shse_pkg::BUCKET_W'(shse_pkg::BUCKETS - 1))
                begin
                    state_next = shse_pkg::BK_IDLE;
                end
            end
            shse_pkg::BK_IDLE:
            begin
                if (pop)
                begin
                    state_next = shse_pkg::BK_EXEC;
                end
            end
            shse_pkg::BK_EXEC:
            begin
                state_next = shse_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = shse_pkg::BK_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        mem_we       = 1'b0;
        wr_addr      = op_reg.hash[shse_pkg::BUCKET_W-1:0];
        wr_row       = rd_row_reg;
        count_next   = count_reg;
        res_status   = shse_pkg::STATUS_OK;
        load_out     = 1'b0;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            shse_pkg::BK_CLEAR:
            begin
                mem_we       = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_row       = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            shse_pkg::BK_IDLE:
            begin
                mem_we = 1'b0;
            end
            shse_pkg::BK_EXEC:
            begin
                load_out = 1'b1;
                unique case (op_reg.cmd)
                    shse_pkg::CMD_ADD:
                    begin
                        if (free_any)
                        begin
                            mem_we       = 1'b1;
                            wr_row.valid = rd_row_reg.valid | free_oh;
                            for (int s = 0; s < S; s++)
                            begin
                                if (free_oh[s])
                                begin
                                    wr_row.hashes[s] = op_reg.hash;
                                end
                            end
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            res_status = shse_pkg::STATUS_FULL;
                        end
                    end
                    shse_pkg::CMD_DELETE:
                    begin
                        if (hit_any)
                        begin
                            mem_we       = 1'b1;
                            wr_row.valid = rd_row_reg.valid & ~hit_oh;
                            count_next   = count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        // contains and the unused code leave the table alone
                        mem_we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shse_pkg::BK_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg     <= res_status;
            found_reg      <= hit_any;
            elem_count_reg <= count_next;
        end
        if (pop)
        begin
            op_reg <= op;
        end
    end

    // bucket store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (pop)
        begin
            rd_row_reg <= mem[op.hash[shse_pkg::BUCKET_W-1:0]];
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.status        = status_reg;
    assign results.found         = found_reg;
    assign results.element_count = elem_count_reg;

    `SHSE_ASSERT_NEXT(a_exec_gives_result, state_reg == shse_pkg::BK_EXEC, out_valid_reg, "operation finished without a result")
    `SHSE_ASSERT_IMPL(a_no_pop_outside_idle, state_reg != shse_pkg::BK_IDLE, !pop, "operation taken while table busy")
    `SHSE_ASSERT_IMPL(a_full_add_no_write, (state_reg == shse_pkg::BK_EXEC) && (op_reg.cmd == shse_pkg::CMD_ADD) && !free_any, !mem_we && (res_status == shse_pkg::STATUS_FULL), "add to full bucket changed the table")
    `SHSE_ASSERT_IMPL(a_count_bound, state_reg != shse_pkg::BK_CLEAR, count_reg <= shse_pkg::COUNT_W'(shse_pkg::TOTAL_SLOTS), "entry count above slot total")

endmodule

`default_nettype wire
